>>> rtl/rbgr_pkg.sv
// Package for the receive bitmap gap reporter.
// Holds the item types, request codes and control/status structs.
// No dependencies; every other file refers to it by scoped names.
`timescale 1ns / 1ps
`default_nettype none

package rbgr_pkg;

  // Fixed field widths of the item formats.
  localparam int unsigned FUNC_W  = 2;
  localparam int unsigned SEQ_W   = 16;
  localparam int unsigned RANGE_W = 12;
  localparam int unsigned GCNT_W  = 4;
  localparam int unsigned RCNT_W  = 13;
  localparam int unsigned TOTAL_W = 13;

  // Request codes carried in the func field.
  localparam logic [FUNC_W-1:0] FUNC_MARK   = 2'd0;
  localparam logic [FUNC_W-1:0] FUNC_REPORT = 2'd1;
  localparam logic [FUNC_W-1:0] FUNC_CLEAR  = 2'd2;

  // One input item.
  typedef struct packed {
    logic [FUNC_W-1:0] func;
    logic [SEQ_W-1:0]  seq;
  } item_t;

  // One result item.
  typedef struct packed {
    logic               gap_valid;
    logic [RANGE_W-1:0] gap_first;
    logic [RANGE_W-1:0] gap_end;
    logic [GCNT_W-1:0]  gap_count;
    logic [RCNT_W-1:0]  received_count;
    logic               last;
  } result_t;

  // Commands from the controller to the datapath.
  typedef struct packed {
    logic clr_init;
    logic clr_step;
    logic mark_init;
    logic mark_wr;
    logic scan_init;
    logic scan_step;
    logic scan_close;
    logic emit_step;
    logic emit_empty;
  } cmd_t;

  // Status from the datapath to the controller.
  typedef struct packed {
    logic clr_last;
    logic scan_done;
    logic gap_none;
    logic emit_last;
  } status_t;

endpackage

`default_nettype wire

>>> rtl/rbgr_ctrl.sv
// Controller state machine for the receive bitmap gap reporter.
// Sequences clear sweeps, marks, scans and result emission; uses rbgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbgr_ctrl (
  input  wire logic                     clk_i,
  input  wire logic                     rst_ni,
  input  wire logic                     start_i,
  input  wire logic [rbgr_pkg::FUNC_W-1:0] func_i,
  output logic                          busy_o,
  output rbgr_pkg::cmd_t                cmd_o,
  input  wire rbgr_pkg::status_t        sts_i
);

  localparam logic [2:0] S_CLEAR = 3'd0;
  localparam logic [2:0] S_IDLE  = 3'd1;
  localparam logic [2:0] S_MARK  = 3'd2;
  localparam logic [2:0] S_SCAN  = 3'd3;
  localparam logic [2:0] S_CLOSE = 3'd4;
  localparam logic [2:0] S_EMIT  = 3'd5;
  localparam logic [2:0] S_EMPTY = 3'd6;

  logic [2:0] state_q, state_d;
  logic       accept;

  assign busy_o = (state_q != S_IDLE);
  assign accept = start_i && !busy_o;

  // Next state and command decode.
  always_comb begin
    state_d = state_q;
    cmd_o   = '0;
    unique case (state_q)
      S_CLEAR: begin
        cmd_o.clr_step = 1'b1;
        if (sts_i.clr_last) begin
          state_d = S_IDLE;
        end
      end
      S_IDLE: begin
        if (accept) begin
          unique case (func_i)
            rbgr_pkg::FUNC_MARK: begin
              cmd_o.mark_init = 1'b1;
              state_d         = S_MARK;
            end
            rbgr_pkg::FUNC_REPORT: begin
              cmd_o.scan_init = 1'b1;
              state_d         = S_SCAN;
            end
            rbgr_pkg::FUNC_CLEAR: begin
              cmd_o.clr_init = 1'b1;
              state_d        = S_CLEAR;
            end
            default: begin
              state_d = S_IDLE;
            end
          endcase
        end
      end
      S_MARK: begin
        cmd_o.mark_wr = 1'b1;
        state_d       = S_IDLE;
      end
      S_SCAN: begin
        cmd_o.scan_step = 1'b1;
        if (sts_i.scan_done) begin
          state_d = S_CLOSE;
        end
      end
      S_CLOSE: begin
        cmd_o.scan_close = 1'b1;
        state_d          = sts_i.gap_none ? S_EMPTY : S_EMIT;
      end
      S_EMIT: begin
        cmd_o.emit_step = 1'b1;
        if (sts_i.emit_last) begin
          state_d = S_IDLE;
        end
      end
      S_EMPTY: begin
        cmd_o.emit_empty = 1'b1;
        state_d          = S_IDLE;
      end
      default: begin
        state_d = S_IDLE;
      end
    endcase
  end

  // State register; reset starts with a clearing sweep of the store.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      state_q <= S_CLEAR;
    end else begin
      state_q <= state_d;
    end
  end

  // A mark, report or clear request always makes the block busy next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    accept && (func_i == rbgr_pkg::FUNC_MARK || func_i == rbgr_pkg::FUNC_REPORT ||
               func_i == rbgr_pkg::FUNC_CLEAR) |=> busy_o)
    else $error("request accepted without entering a busy state");

  // A mark is followed by its store write in the mark state, after which the block is idle again.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    cmd_o.mark_init |=> cmd_o.mark_wr ##1 !busy_o)
    else $error("mark did not complete in two cycles");

endmodule

`default_nettype wire

>>> rtl/rbgr_dp.sv
// Datapath for the receive bitmap gap reporter: received-bit store, counters,
// gap range buffer and the result register. Driven by rbgr_ctrl; uses rbgr_pkg.
`timescale 1ns / 1ps
`default_nettype none

module rbgr_dp #(
  parameter int unsigned MAX_PACKETS = 4096,
  parameter int unsigned MAX_GAPS    = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire rbgr_pkg::item_t              item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rbgr_pkg::TOTAL_W-1:0] cfg_wdata_i,
  input  wire rbgr_pkg::cmd_t               cmd_i,
  output rbgr_pkg::status_t                 sts_o,
  output logic                              res_strobe_o,
  output rbgr_pkg::result_t                 res_o
);

  localparam int unsigned AW  = $clog2(MAX_PACKETS);
  localparam int unsigned CW  = $clog2(MAX_PACKETS + 1);
  localparam int unsigned TW  = (CW > rbgr_pkg::TOTAL_W) ? CW : rbgr_pkg::TOTAL_W;
  localparam int unsigned SW  = (CW > rbgr_pkg::SEQ_W) ? CW : rbgr_pkg::SEQ_W;
  localparam int unsigned EW  = (AW > rbgr_pkg::RANGE_W) ? AW : rbgr_pkg::RANGE_W;
  localparam int unsigned GIW = (MAX_GAPS > 1) ? $clog2(MAX_GAPS) : 1;
  localparam int unsigned NW  = $clog2(MAX_GAPS + 1);
  localparam int unsigned XW  = (NW > rbgr_pkg::GCNT_W) ? NW : rbgr_pkg::GCNT_W;

  // Configured packet total, saturated at capacity.
  logic [rbgr_pkg::TOTAL_W-1:0] total_q;
  logic [CW-1:0]                tot_eff;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      total_q <= '0;
    end else if (cfg_we_i) begin
      total_q <= cfg_wdata_i;
    end
  end

  assign tot_eff = (TW'(total_q) > TW'(MAX_PACKETS)) ? CW'(MAX_PACKETS) : CW'(total_q);

  // Received-bit store, one bit per sequence number.
  logic          map_mem [MAX_PACKETS];
  logic          map_we;
  logic [AW-1:0] map_wa;
  logic          map_wd;
  logic [AW-1:0] map_ra;
  logic          rd_bit_q;

  // Control counters and flags.
  logic [AW-1:0]                clr_idx_q;
  logic [rbgr_pkg::RCNT_W-1:0]  rcv_q;
  logic [AW-1:0]                seq_q;
  logic                         seq_ok_q;
  logic [CW-1:0]                scan_idx_q;
  logic                         p_v_q;
  logic [AW-1:0]                p_idx_q;
  logic                         in_gap_q;
  logic [AW-1:0]                gstart_q;
  logic [NW-1:0]                n_q;
  logic [NW-1:0]                rd_idx_q;

  logic scan_more;
  logic scan_iss;
  logic gaps_free;
  logic seq_ok;
  logic mark_new;

  assign gaps_free = (n_q < NW'(MAX_GAPS));
  assign scan_more = (scan_idx_q < tot_eff) && gaps_free;
  assign scan_iss  = cmd_i.scan_step && scan_more;
  assign seq_ok    = (SW'(item_i.seq) < SW'(tot_eff));
  assign mark_new  = cmd_i.mark_wr && seq_ok_q && !rd_bit_q;

  // Store port selection: clear sweep writes zero, a new mark writes one.
  always_comb begin
    map_we = cmd_i.clr_step || mark_new;
    map_wa = cmd_i.clr_step ? clr_idx_q : seq_q;
    map_wd = !cmd_i.clr_step;
    map_ra = cmd_i.scan_step ? scan_idx_q[AW-1:0] : item_i.seq[AW-1:0];
  end

  always_ff @(posedge clk_i) begin
    if (map_we) begin
      map_mem[map_wa] <= map_wd;
    end
    rd_bit_q <= map_mem[map_ra];
  end

  // Mark request: latch the number and whether it is in range.
  always_ff @(posedge clk_i) begin
    if (cmd_i.mark_init) begin
      seq_q <= item_i.seq[AW-1:0];
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      seq_ok_q <= 1'b0;
    end else if (cmd_i.mark_init) begin
      seq_ok_q <= seq_ok;
    end
  end

  // Clear sweep index and received count.
  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      clr_idx_q <= '0;
      rcv_q     <= '0;
    end else if (cmd_i.clr_init) begin
      clr_idx_q <= '0;
      rcv_q     <= '0;
    end else begin
      if (cmd_i.clr_step) begin
        clr_idx_q <= clr_idx_q + AW'(1);
      end
      if (mark_new) begin
        rcv_q <= rcv_q + rbgr_pkg::RCNT_W'(1);
      end
    end
  end

  // Gap range buffer, written during the scan and read during emission.
  logic [2*AW-1:0] gap_mem [MAX_GAPS];
  logic            gap_we;
  logic [2*AW-1:0] gap_wd;
  logic            emit_rd;
  logic [2*AW-1:0] gap_rd_q;
  logic            p_fill;
  logic            p_close;
  logic            end_close;

  // A fetched bit opens a gap when clear, closes one when set.
  assign p_fill    = p_v_q && gaps_free && !rd_bit_q && !in_gap_q;
  assign p_close   = p_v_q && gaps_free && rd_bit_q && in_gap_q;
  assign end_close = cmd_i.scan_close && in_gap_q && gaps_free;
  assign gap_we    = p_close || end_close;
  assign gap_wd    = p_close ? {gstart_q, p_idx_q - AW'(1)}
                             : {gstart_q, AW'(tot_eff - CW'(1))};
  assign emit_rd   = cmd_i.emit_step && (rd_idx_q < n_q);

  always_ff @(posedge clk_i) begin
    if (gap_we) begin
      gap_mem[n_q[GIW-1:0]] <= gap_wd;
    end
    if (emit_rd) begin
      gap_rd_q <= gap_mem[rd_idx_q[GIW-1:0]];
    end
  end

  // Scan pipeline: address issue, then bit evaluation in the cycle after.
  always_ff @(posedge clk_i) begin
    p_idx_q <= scan_idx_q[AW-1:0];
    if (p_fill) begin
      gstart_q <= p_idx_q;
    end
  end

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      scan_idx_q <= '0;
      p_v_q      <= 1'b0;
      in_gap_q   <= 1'b0;
      n_q        <= '0;
      rd_idx_q   <= '0;
    end else if (cmd_i.scan_init) begin
      scan_idx_q <= '0;
      p_v_q      <= 1'b0;
      in_gap_q   <= 1'b0;
      n_q        <= '0;
      rd_idx_q   <= '0;
    end else begin
      p_v_q <= scan_iss;
      if (scan_iss) begin
        scan_idx_q <= scan_idx_q + CW'(1);
      end
      if (p_fill) begin
        in_gap_q <= 1'b1;
      end else if (gap_we) begin
        in_gap_q <= 1'b0;
      end
      if (gap_we) begin
        n_q <= n_q + NW'(1);
      end
      if (emit_rd) begin
        rd_idx_q <= rd_idx_q + NW'(1);
      end
    end
  end

  // Result register.
  logic out_v_q;
  logic out_empty_q;
  logic out_last_q;

  always_ff @(posedge clk_i or negedge rst_ni) begin
    if (!rst_ni) begin
      out_v_q     <= 1'b0;
      out_empty_q <= 1'b0;
      out_last_q  <= 1'b0;
    end else begin
      out_v_q     <= emit_rd || cmd_i.emit_empty;
      out_empty_q <= cmd_i.emit_empty;
      out_last_q  <= cmd_i.emit_empty || (emit_rd && (rd_idx_q == n_q - NW'(1)));
    end
  end

  // Result fields, masked to the item widths.
  logic [EW-1:0] start_ext;
  logic [EW-1:0] end_ext;
  logic [XW-1:0] n_ext;

  assign start_ext = EW'(gap_rd_q[2*AW-1:AW]);
  assign end_ext   = EW'(gap_rd_q[AW-1:0]);
  assign n_ext     = XW'(n_q);

  always_comb begin
    res_o.gap_valid      = !out_empty_q;
    res_o.gap_first      = out_empty_q ? '0 : start_ext[rbgr_pkg::RANGE_W-1:0];
    res_o.gap_end        = out_empty_q ? '0 : end_ext[rbgr_pkg::RANGE_W-1:0];
    res_o.gap_count      = n_ext[rbgr_pkg::GCNT_W-1:0];
    res_o.received_count = rcv_q;
    res_o.last           = out_last_q;
  end

  assign res_strobe_o = out_v_q;

  // Status back to the controller.
  always_comb begin
    sts_o.clr_last  = (clr_idx_q == AW'(MAX_PACKETS - 1));
    sts_o.scan_done = !scan_more && !p_v_q;
    sts_o.gap_none  = (n_q == '0) && !in_gap_q;
    sts_o.emit_last = (rd_idx_q == n_q - NW'(1));
  end

  // The range count never exceeds the buffer depth.
  assert property (@(posedge clk_i) disable iff (!rst_ni) n_q <= NW'(MAX_GAPS))
    else $error("gap count beyond buffer depth");

  // Ranges are only recorded while a scan runs or is being closed.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    gap_we |-> (cmd_i.scan_step || cmd_i.scan_close))
    else $error("gap buffer written outside a scan");

  // The final result of a report is never followed by a strobe next cycle.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    out_v_q && out_last_q |=> !out_v_q)
    else $error("result strobe after the final result");

  // The received count moves only on a clear or a newly set bit.
  assert property (@(posedge clk_i) disable iff (!rst_ni)
    !cmd_i.clr_init && !mark_new |=> $stable(rcv_q))
    else $error("received count changed without a new mark");

endmodule

`default_nettype wire

>>> rtl/receive_bitmap_gap_reporter.sv
// Top level: controller and datapath of the receive bitmap gap reporter; uses rbgr_pkg.
// A mark stays busy until its store write is done, so the next mark waits for that write.
// A report scans one number per cycle, then emits one result per recorded range, or a single
// empty result when nothing is missing.
// A clear, and reset, sweep the store one entry per cycle and stay busy until the sweep ends.
// Reset also zeroes the total and the count; results leave a register, one per cycle.
`timescale 1ns / 1ps
`default_nettype none

module receive_bitmap_gap_reporter #(
  parameter int unsigned MAX_PACKETS = 4096,
  parameter int unsigned MAX_GAPS    = 8
) (
  input  wire logic                         clk_i,
  input  wire logic                         rst_ni,
  input  wire logic                         start_i,
  output logic                              busy_o,
  input  wire rbgr_pkg::item_t              item_i,
  input  wire logic                         cfg_we_i,
  input  wire logic [rbgr_pkg::TOTAL_W-1:0] cfg_wdata_i,
  output logic                              res_strobe_o,
  output rbgr_pkg::result_t                 res_o
);

  rbgr_pkg::cmd_t    cmd;
  rbgr_pkg::status_t sts;

  // Request sequencing.
  rbgr_ctrl u_ctrl (
    .clk_i  (clk_i),
    .rst_ni (rst_ni),
    .start_i(start_i),
    .func_i (item_i.func),
    .busy_o (busy_o),
    .cmd_o  (cmd),
    .sts_i  (sts)
  );

  // Store, scan and result datapath.
  rbgr_dp #(
    .MAX_PACKETS(MAX_PACKETS),
    .MAX_GAPS   (MAX_GAPS)
  ) u_dp (
    .clk_i       (clk_i),
    .rst_ni      (rst_ni),
    .item_i      (item_i),
    .cfg_we_i    (cfg_we_i),
    .cfg_wdata_i (cfg_wdata_i),
    .cmd_i       (cmd),
    .sts_o       (sts),
    .res_strobe_o(res_strobe_o),
    .res_o       (res_o)
  );

endmodule

`default_nettype wire

>>> test/tb.sv
// Testbench for receive_bitmap_gap_reporter: directed and random requests against a predictor.
// Depends on rbgr_pkg for the item and result types and the request codes.
`timescale 1ns / 1ps

module tb;

  localparam int unsigned MAP_DEPTH = 4096;
  localparam int unsigned GAP_SLOTS = 8;
  localparam int unsigned QUIET_LIMIT = 20000;
  localparam logic [rbgr_pkg::FUNC_W-1:0] FUNC_UNUSED = 2'd3;

  logic clk_i;
  logic rst_ni;
  logic start_i;
  logic busy_o;
  rbgr_pkg::item_t item_i;
  logic cfg_we_i;
  logic [rbgr_pkg::TOTAL_W-1:0] cfg_wdata_i;
  logic res_strobe_o;
  rbgr_pkg::result_t res_o;

  receive_bitmap_gap_reporter u_top (
    .clk_i        (clk_i),
    .rst_ni       (rst_ni),
    .start_i      (start_i),
    .busy_o       (busy_o),
    .item_i       (item_i),
    .cfg_we_i     (cfg_we_i),
    .cfg_wdata_i  (cfg_wdata_i),
    .res_strobe_o (res_strobe_o),
    .res_o        (res_o)
  );

  // Free-running 10 ns clock.
  always begin
    clk_i = 1'b0;
    #5;
    clk_i = 1'b1;
    #5;
  end

  // Predictor state: one arrived bit per sequence number, the count and the packet total.
  bit arrived [MAP_DEPTH];
  logic [rbgr_pkg::RCNT_W-1:0] arrived_total;
  logic [rbgr_pkg::TOTAL_W-1:0] pkt_total;
  rbgr_pkg::result_t expected_gaps[$];
  int unsigned err_count;
  int unsigned quiet_cycles;
  rbgr_pkg::result_t want_gap;

  task automatic report_error(input string msg);
    $display("tb: %s", msg);
    err_count++;
  endtask

  task automatic check_field(input string name, input int unsigned got,
                             input int unsigned want);
    if (got != want) begin
      report_error($sformatf("%s got %0d want %0d", name, got, want));
    end
  endtask

  function automatic int unsigned effective_total();
    return (pkt_total > MAP_DEPTH) ? MAP_DEPTH : int'(pkt_total);
  endfunction

  function automatic void clear_arrived();
    foreach (arrived[k]) arrived[k] = 1'b0;
    arrived_total = '0;
  endfunction

  // Scan the map from zero up to the total and queue the missing ranges of one report.
  function automatic void predict_report();
    int unsigned eff;
    int unsigned i;
    int unsigned first;
    int unsigned n;
    rbgr_pkg::result_t r;
    rbgr_pkg::result_t found[$];
    eff = effective_total();
    i = 0;
    n = 0;
    while (n < GAP_SLOTS && i < eff) begin
      while (i < eff && arrived[i]) i++;
      if (i >= eff) break;
      first = i;
      while (i < eff && !arrived[i]) i++;
      r = '0;
      r.gap_valid = 1'b1;
      r.gap_first = 12'(first);
      r.gap_end = 12'(i - 1);
      found.push_back(r);
      n++;
    end
    if (n == 0) begin
      r = '0;
      r.received_count = arrived_total;
      r.last = 1'b1;
      found.push_back(r);
    end else begin
      foreach (found[k]) begin
        found[k].gap_count = 4'(n);
        found[k].received_count = arrived_total;
        found[k].last = (k == n - 1);
      end
    end
    foreach (found[k]) expected_gaps.push_back(found[k]);
  endfunction

  // Update the predictor for one accepted request.
  function automatic void predict_request(input rbgr_pkg::item_t it);
    case (it.func)
      rbgr_pkg::FUNC_MARK: begin
        if (it.seq < effective_total() && !arrived[it.seq]) begin
          arrived[it.seq] = 1'b1;
          arrived_total = arrived_total + 1'b1;
        end
      end
      rbgr_pkg::FUNC_REPORT: predict_report();
      rbgr_pkg::FUNC_CLEAR: clear_arrived();
      default: ;
    endcase
  endfunction

  // Present one item from the falling edge and hold it until a rising edge sees busy low.
  task automatic issue_request(input logic [rbgr_pkg::FUNC_W-1:0] func,
                               input logic [rbgr_pkg::SEQ_W-1:0] seq);
    rbgr_pkg::item_t it;
    it.func = func;
    it.seq = seq;
    @(negedge clk_i);
    start_i <= 1'b1;
    item_i <= it;
    do @(posedge clk_i); while (busy_o);
    predict_request(it);
  endtask

  task automatic idle_cycles(input int unsigned n);
    repeat (n) begin
      @(negedge clk_i);
      start_i <= 1'b0;
    end
  endtask

  // Drain all expected results, let a mark finish, then wait for the block to go idle.
  task automatic quiesce();
    idle_cycles(1);
    while (expected_gaps.size() != 0) @(posedge clk_i);
    repeat (8) @(posedge clk_i);
    while (busy_o) @(posedge clk_i);
  endtask

  task automatic write_total(input logic [rbgr_pkg::TOTAL_W-1:0] value);
    quiesce();
    @(negedge clk_i);
    cfg_we_i <= 1'b1;
    cfg_wdata_i <= value;
    @(posedge clk_i);
    pkt_total = value;
    @(negedge clk_i);
    cfg_we_i <= 1'b0;
  endtask

  // Compare every strobed result with the oldest expected range.
  always @(posedge clk_i) begin
    if (rst_ni && res_strobe_o) begin
      if (expected_gaps.size() == 0) begin
        report_error($sformatf("unexpected result first %0d end %0d",
                               res_o.gap_first, res_o.gap_end));
      end else begin
        want_gap = expected_gaps.pop_front();
        check_field("gap_valid", res_o.gap_valid, want_gap.gap_valid);
        check_field("gap_first", res_o.gap_first, want_gap.gap_first);
        check_field("gap_end", res_o.gap_end, want_gap.gap_end);
        check_field("gap_count", res_o.gap_count, want_gap.gap_count);
        check_field("received_count", res_o.received_count, want_gap.received_count);
        check_field("last", res_o.last, want_gap.last);
      end
    end
  end

  // Watchdog on cycles in which neither an item nor a result moves.
  always @(posedge clk_i) begin
    if ((start_i && !busy_o && rst_ni) || res_strobe_o) begin
      quiet_cycles = 0;
    end else begin
      quiet_cycles++;
      if (quiet_cycles >= QUIET_LIMIT) begin
        $display("tb: done, errors");
        $finish;
      end
    end
  end

  // Report with total zero, a mark that cannot land and the unused selector.
  task automatic test_empty_and_ignored();
    write_total(13'd0);
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd0);
    issue_request(FUNC_UNUSED, 16'hFFFF);
  endtask

  // Fill a tiny transfer, mark one number twice, and report nothing missing.
  task automatic test_repeat_and_full();
    write_total(13'd2);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd0);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd1);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd1);
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
  endtask

  // Out-of-range marks, then more gaps than the report can hold.
  task automatic test_gap_cap();
    write_total(13'd20);
    issue_request(rbgr_pkg::FUNC_MARK, 16'hFFFF);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd20);
    for (int s = 3; s <= 17; s += 2) issue_request(rbgr_pkg::FUNC_MARK, 16'(s));
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
  endtask

  // Lower the total below marked bits: they stay counted until a clear.
  task automatic test_lowered_total();
    write_total(13'd4);
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
    issue_request(rbgr_pkg::FUNC_CLEAR, 16'd0);
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
  endtask

  // A total above capacity is used as the full store size.
  task automatic test_saturated_total();
    write_total(13'h1FFF);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd4095);
    issue_request(rbgr_pkg::FUNC_MARK, 16'd4096);
    issue_request(rbgr_pkg::FUNC_REPORT, 16'd0);
  endtask

  // One phase of random requests at a fixed total, mostly marks in range.
  task automatic random_phase(input logic [rbgr_pkg::TOTAL_W-1:0] total,
                              input int unsigned n_items, input int unsigned rep_pct,
                              input bit with_gaps);
    int unsigned burst_left;
    int unsigned eff;
    int unsigned pick;
    int unsigned sel;
    logic [rbgr_pkg::SEQ_W-1:0] seq;
    logic [rbgr_pkg::FUNC_W-1:0] func;
    write_total(total);
    eff = effective_total();
    burst_left = 0;
    for (int n = 0; n < n_items; n++) begin
      pick = $urandom_range(99);
      sel = $urandom_range(99);
      if (sel < 15 || eff == 0) begin
        seq = 16'($urandom);
      end else if (sel < 55 && eff > 64) begin
        seq = 16'($urandom_range(63));
      end else begin
        seq = 16'($urandom_range(eff - 1));
      end
      if (pick < rep_pct) begin
        func = rbgr_pkg::FUNC_REPORT;
      end else if (pick < rep_pct + 5) begin
        func = FUNC_UNUSED;
      end else if (pick < rep_pct + 9) begin
        func = rbgr_pkg::FUNC_CLEAR;
      end else begin
        func = rbgr_pkg::FUNC_MARK;
      end
      if (with_gaps) begin
        if (burst_left == 0) begin
          idle_cycles($urandom_range(1, 8));
          burst_left = $urandom_range(1, 16);
        end
        burst_left--;
      end
      issue_request(func, seq);
    end
  endtask

  task automatic test_random();
    random_phase(13'd16, 24, 20, 1'b1);
    random_phase(13'd1, 10, 25, 1'b0);
    random_phase(13'd64, 24, 20, 1'b1);
    random_phase(13'($urandom_range(2, 100)), 16, 20, 1'b0);
    random_phase(13'd4096, 12, 8, 1'b1);
    random_phase(13'h1FFF, 10, 8, 1'b1);
    random_phase(13'd300, 10, 15, 1'b1);
  endtask

  initial begin
    rst_ni = 1'b0;
    start_i = 1'b0;
    item_i = '0;
    cfg_we_i = 1'b0;
    cfg_wdata_i = '0;
    err_count = 0;
    quiet_cycles = 0;
    pkt_total = '0;
    clear_arrived();
    repeat (12) @(posedge clk_i);
    @(negedge clk_i);
    rst_ni <= 1'b1;

    test_empty_and_ignored();
    test_repeat_and_full();
    test_gap_cap();
    test_lowered_total();
    test_saturated_total();
    test_random();

    // Drain, then give a pending clear or mark time to show any stray result.
    quiesce();
    repeat (8) @(posedge clk_i);
    if (err_count == 0) begin
      $display("tb: done, clean");
    end else begin
      $display("tb: done, errors");
    end
    $finish;
  end

endmodule

>>> filelist.f
rtl/rbgr_pkg.sv
rtl/rbgr_ctrl.sv
rtl/rbgr_dp.sv
rtl/receive_bitmap_gap_reporter.sv
test/tb.sv
